@@ src/window_min_max_clamp_core_assert.svh @@
// ----------------------------------------------------------------------------
// Window min/max clamp assertion macros
// Concurrent assertion wrappers, compiled out under synthesis.
// ----------------------------------------------------------------------------
`ifndef WINDOW_MIN_MAX_CLAMP_CORE_ASSERT_SVH
`define WINDOW_MIN_MAX_CLAMP_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define WMMC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("wmmc assertion failed");

`define WMMC_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("wmmc forbidden condition seen");

`else

`define WMMC_ASSERT(label, clk, rst_n, prop)

`define WMMC_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

@@ src/wmmc_pkg.sv @@
// ----------------------------------------------------------------------------
// Window min/max clamp package
// Shared widths, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package wmmc_pkg;

  localparam int unsigned DataW = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_FINISH
  } wmmc_state_e;

  typedef struct packed {
    logic accept;
    logic issue_rd;
    logic load_out;
  } wmmc_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } wmmc_status_t;

endpackage

@@ src/wmmc_ram.sv @@
// ----------------------------------------------------------------------------
// Window min/max clamp RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module wmmc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/wmmc_ctrl.sv @@
// ----------------------------------------------------------------------------
// Window min/max clamp controller
// Sequences accept, window scan and result load for one word at a time.
// ----------------------------------------------------------------------------
module wmmc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  wmmc_pkg::wmmc_status_t status_i,
  output wmmc_pkg::wmmc_cmd_t    cmd_o
);

  wmmc_pkg::wmmc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wmmc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    in_stall_o     = 1'b1;
    unique case (state_q)
      wmmc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = wmmc_pkg::ST_SCAN;
        end
      end
      wmmc_pkg::ST_SCAN: begin
        cmd_o.issue_rd = 1'b1;
        if (status_i.scan_last) begin
          state_d = wmmc_pkg::ST_LAST;
        end
      end
      wmmc_pkg::ST_LAST: begin
        state_d = wmmc_pkg::ST_FINISH;
      end
      wmmc_pkg::ST_FINISH: begin
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = wmmc_pkg::ST_IDLE;
        end
      end
    endcase
  end

endmodule

@@ src/wmmc_dp.sv @@
// ----------------------------------------------------------------------------
// Window min/max clamp datapath
// Sample ring, fill tracking, min/max scan, clamp and output register.
// ----------------------------------------------------------------------------
module wmmc_dp #(
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  wmmc_pkg::wmmc_cmd_t                cmd_i,
  output wmmc_pkg::wmmc_status_t             status_o,
  input  logic [wmmc_pkg::DataW-1:0]         lux_sample_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [wmmc_pkg::DataW-1:0]         clamped_lux_o,
  output logic [wmmc_pkg::DataW-1:0]         window_min_o,
  output logic [wmmc_pkg::DataW-1:0]         window_max_o,
  output logic                               window_full_o
);

  localparam int unsigned AddrW = $clog2(WINDOW_DEPTH);
  localparam int unsigned CntW  = $clog2(WINDOW_DEPTH + 1);

  logic [AddrW-1:0]             slot_q, slot_d;
  logic [CntW-1:0]              fill_q, fill_d;
  logic [CntW-1:0]              fill_m1;
  logic [AddrW-1:0]             rd_cnt_q, rd_cnt_d;
  logic                         rd_vld_q;
  logic                         out_valid_q, out_valid_d;
  logic [wmmc_pkg::DataW-1:0]   sample_q;
  logic [wmmc_pkg::DataW-1:0]   min_q, max_q;
  logic [wmmc_pkg::DataW-1:0]   out_lux_q, out_min_q, out_max_q;
  logic                         out_full_q;
  logic [wmmc_pkg::DataW-1:0]   rdata;
  logic [wmmc_pkg::DataW-1:0]   clamp_lux;
  logic                         full;

  wmmc_ram #(
    .WIDTH (wmmc_pkg::DataW),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept),
    .waddr_i (slot_q),
    .wdata_i (lux_sample_i),
    .re_i    (cmd_i.issue_rd),
    .raddr_i (rd_cnt_q),
    .rdata_o (rdata)
  );

  assign full    = (fill_q == CntW'(WINDOW_DEPTH));
  assign fill_m1 = fill_q - CntW'(1);

  always_comb begin
    slot_d      = slot_q;
    fill_d      = fill_q;
    rd_cnt_d    = rd_cnt_q;
    out_valid_d = out_valid_q;
    if (cmd_i.accept) begin
      slot_d   = (slot_q == AddrW'(WINDOW_DEPTH - 1)) ? '0 : slot_q + AddrW'(1);
      fill_d   = full ? fill_q : fill_q + CntW'(1);
      rd_cnt_d = '0;
    end else if (cmd_i.issue_rd) begin
      rd_cnt_d = rd_cnt_q + AddrW'(1);
    end
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      fill_q      <= '0;
      rd_cnt_q    <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      slot_q      <= slot_d;
      fill_q      <= fill_d;
      rd_cnt_q    <= rd_cnt_d;
      rd_vld_q    <= cmd_i.issue_rd;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    clamp_lux = sample_q;
    if (full) begin
      if (sample_q < min_q) begin
        clamp_lux = min_q;
      end else if (sample_q > max_q) begin
        clamp_lux = max_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= lux_sample_i;
      min_q    <= lux_sample_i;
      max_q    <= lux_sample_i;
    end else if (rd_vld_q) begin
      if (rdata < min_q) begin
        min_q <= rdata;
      end
      if (rdata > max_q) begin
        max_q <= rdata;
      end
    end
    if (cmd_i.load_out) begin
      out_lux_q  <= clamp_lux;
      out_min_q  <= min_q;
      out_max_q  <= max_q;
      out_full_q <= full;
    end
  end

  assign status_o.scan_last = (rd_cnt_q == fill_m1[AddrW-1:0]);
  assign status_o.out_busy  = out_valid_q && out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign clamped_lux_o = out_lux_q;
  assign window_min_o  = out_min_q;
  assign window_max_o  = out_max_q;
  assign window_full_o = out_full_q;

endmodule

@@ src/window_min_max_clamp_core.sv @@
// ----------------------------------------------------------------------------
// Window min/max clamp core
// Each accepted sample is stored in a ring of the last WINDOW_DEPTH samples;
// the block then scans the filled entries through the single read port of the
// ring RAM, one entry per cycle, and returns the sample (clamped to the
// window bounds once the window is full) with the window minimum, maximum and
// full flag. The block takes no new sample until the current one has been
// loaded into the output register; a finished word waits in the output
// register, so the next sample is taken while it is still stalled, and a
// load waits only if the previous word has not been taken yet.
// ----------------------------------------------------------------------------
`include "window_min_max_clamp_core_assert.svh"

module window_min_max_clamp_core #(
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [wmmc_pkg::DataW-1:0] lux_sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [wmmc_pkg::DataW-1:0] clamped_lux_o,
  output logic [wmmc_pkg::DataW-1:0] window_min_o,
  output logic [wmmc_pkg::DataW-1:0] window_max_o,
  output logic                       window_full_o
);

  wmmc_pkg::wmmc_cmd_t    cmd;
  wmmc_pkg::wmmc_status_t status;

  wmmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wmmc_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .lux_sample_i  (lux_sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .clamped_lux_o (clamped_lux_o),
    .window_min_o  (window_min_o),
    .window_max_o  (window_max_o),
    .window_full_o (window_full_o)
  );

  `WMMC_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)
  `WMMC_ASSERT(a_bounds_order, clk_i, rst_ni, out_valid_o |-> (window_min_o <= window_max_o))
  `WMMC_ASSERT(a_clamp_in_bounds, clk_i, rst_ni,
               (out_valid_o && window_full_o) |->
               ((clamped_lux_o >= window_min_o) && (clamped_lux_o <= window_max_o)))
  `WMMC_ASSERT_NEVER(a_accept_and_load, clk_i, rst_ni, cmd.accept && cmd.load_out)

endmodule
